// ===== hw/rtl/x86_bcd_adjust_unit_assert.svh =====
// assertion helpers for the decimal adjust unit
`ifndef X86_BCD_ADJUST_UNIT_ASSERT_SVH
`define X86_BCD_ADJUST_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define XBCD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define XBCD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/xbcd_pkg.sv =====
package xbcd_pkg;

   typedef enum logic [2:0] {
      OP_DAA = 3'd0,
      OP_DAS = 3'd1,
      OP_AAA = 3'd2,
      OP_AAS = 3'd3,
      OP_AAM = 3'd4,
      OP_AAD = 3'd5
   } op_type;

   localparam logic [5:0] FLAG_CF = 6'h01;
   localparam logic [5:0] FLAG_AF = 6'h02;
   localparam logic [5:0] FLAG_SF = 6'h04;
   localparam logic [5:0] FLAG_ZF = 6'h08;
   localparam logic [5:0] FLAG_PF = 6'h10;
   localparam logic [5:0] FLAG_OF = 6'h20;
   localparam logic [5:0] MASK_ADJ = FLAG_CF | FLAG_AF;
   localparam logic [5:0] MASK_ARITH = FLAG_CF | FLAG_AF | FLAG_SF | FLAG_ZF | FLAG_PF;
   localparam logic [5:0] MASK_ALL = MASK_ARITH | FLAG_OF;

   localparam logic [7:0] ADJ_LOW = 8'h06;
   localparam logic [7:0] ADJ_HIGH = 8'h60;
   localparam logic [7:0] DAS_LIMIT = 8'h99;
   localparam logic [7:0] DAA_LIMIT = 8'h9F;
   localparam logic [7:0] AAA_WRAP = 8'hF9;
   localparam logic [7:0] NIBBLE_MASK = 8'h0F;
   localparam logic [3:0] DIGIT_MAX = 4'h9;

   // number of restoring division steps done in each of the first two stages
   localparam int DIV_STEPS = 4;

   typedef struct packed {
      logic       q;
      logic [7:0] rem;
   } div_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  al;
      logic [7:0]  base;
      logic [7:0]  res_al;
      logic [7:0]  res_ah;
      logic        res_cf;
      logic        res_af;
      logic [15:0] prod;
      logic [7:0]  rem;
      logic [3:0]  quo_hi;
   } s1_type;

   typedef struct packed {
      logic [7:0] al;
      logic [7:0] ah;
      logic       cf;
      logic       af;
      logic       of;
      logic [5:0] mask;
      logic       derr;
   } s2_type;

   // one restoring division step
   function automatic div_type div_step(input logic [7:0] rem, input logic dbit,
                                        input logic [7:0] divisor);
      logic [8:0] trial;
      logic [8:0] diff;
      div_type    res;
      trial = {rem, dbit};
      diff = trial - {1'b0, divisor};
      if (trial >= {1'b0, divisor}) begin
         res.q = 1'b1;
         res.rem = diff[7:0];
      end else begin
         res.q = 1'b0;
         res.rem = trial[7:0];
      end
      return res;
   endfunction

   function automatic logic even_parity(input logic [7:0] v);
      return ~(^v);
   endfunction

endpackage

// ===== hw/rtl/x86_bcd_adjust_unit.sv =====
// x86 decimal adjust unit (DAA, DAS, AAA, AAS, AAM, AAD): takes one instruction per
// clock as long as the result side keeps taking them, and returns the results in order,
// registered through stage one, stage two and stage three. Stage one does the BCD
// corrections, the AAD multiply and the top four steps of the AAM restoring division;
// stage two does the other four division steps and the AAD add; stage three forms the
// status flags into the output register. Back-pressure stalls the pipe without losing
// bubbles' worth of throughput: empty stages still fill while a result waits.
`include "x86_bcd_adjust_unit_assert.svh"

module x86_bcd_adjust_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // al_in[7:0], ah_in[15:8], carry_in[16], aux_carry_in[17], imm_base[25:18], zero pad
   input  logic [31:0] req_tdata,
   // operation[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // al_out[7:0], ah_out[15:8], carry_out[16], aux_carry_out[17], sign_out[18],
   // zero_out[19], parity_out[20], overflow_out[21], flags_written[27:22],
   // divide_error[28], zero pad
   output logic [31:0] rsp_tdata
);

   logic                s1_valid_ff, s1_valid_in;
   logic                s2_valid_ff, s2_valid_in;
   logic                s3_valid_ff, s3_valid_in;
   xbcd_pkg::s1_type    s1_data_ff, s1_data_in;
   xbcd_pkg::s2_type    s2_data_ff, s2_data_in;
   logic [31:0]         s3_data_ff, s3_data_in;
   logic                en1, en2, en3;

   assign en3 = !s3_valid_ff || rsp_tready;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_tready = en1;

   assign s1_valid_in = en1 ? req_tvalid : s1_valid_ff;
   assign s2_valid_in = en2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = en3 ? s2_valid_ff : s3_valid_ff;

   // stage one: bcd corrections, product, upper quotient digits
   always_comb begin
      logic [7:0]        al, ah, base, t;
      logic              cf, af, adj;
      logic [7:0]        rem;
      xbcd_pkg::div_type st;
      xbcd_pkg::op_type  op;
      al = req_tdata[7:0];
      ah = req_tdata[15:8];
      cf = req_tdata[16];
      af = req_tdata[17];
      base = req_tdata[25:18];
      op = xbcd_pkg::op_type'(req_tuser);
      adj = (al[3:0] > xbcd_pkg::DIGIT_MAX) || af;
      s1_data_in.op = op;
      s1_data_in.al = al;
      s1_data_in.base = base;
      s1_data_in.res_al = al;
      s1_data_in.res_ah = ah;
      s1_data_in.res_cf = 1'b0;
      s1_data_in.res_af = 1'b0;
      t = al;
      case (op)
         xbcd_pkg::OP_DAA: begin
            if (adj) t = al + xbcd_pkg::ADJ_LOW;
            s1_data_in.res_af = adj;
            if (t > xbcd_pkg::DAA_LIMIT || cf) begin
               t = t + xbcd_pkg::ADJ_HIGH;
               s1_data_in.res_cf = 1'b1;
            end
            s1_data_in.res_al = t;
         end
         xbcd_pkg::OP_DAS: begin
            if (adj) t = al - xbcd_pkg::ADJ_LOW;
            s1_data_in.res_af = adj;
            s1_data_in.res_cf = adj && ((al < xbcd_pkg::ADJ_LOW) || cf);
            if (al > xbcd_pkg::DAS_LIMIT || cf) begin
               t = t - xbcd_pkg::ADJ_HIGH;
               s1_data_in.res_cf = 1'b1;
            end
            s1_data_in.res_al = t;
         end
         xbcd_pkg::OP_AAA: begin
            s1_data_in.res_cf = adj;
            s1_data_in.res_af = adj;
            if (adj) begin
               s1_data_in.res_ah = ah + 8'd1 + {7'd0, al > xbcd_pkg::AAA_WRAP};
               s1_data_in.res_al = (al + xbcd_pkg::ADJ_LOW) & xbcd_pkg::NIBBLE_MASK;
            end else begin
               s1_data_in.res_al = al & xbcd_pkg::NIBBLE_MASK;
            end
         end
         xbcd_pkg::OP_AAS: begin
            s1_data_in.res_cf = adj;
            s1_data_in.res_af = adj;
            if (adj) begin
               s1_data_in.res_ah = ah - 8'd1 - {7'd0, al < xbcd_pkg::ADJ_LOW};
               s1_data_in.res_al = (al - xbcd_pkg::ADJ_LOW) & xbcd_pkg::NIBBLE_MASK;
            end else begin
               s1_data_in.res_al = al & xbcd_pkg::NIBBLE_MASK;
            end
         end
         default: begin
         end
      endcase
      s1_data_in.prod = {8'd0, ah} * {8'd0, base};
      rem = 8'd0;
      for (int i = 0; i < xbcd_pkg::DIV_STEPS; i++) begin
         st = xbcd_pkg::div_step(rem, al[7 - i], base);
         rem = st.rem;
         s1_data_in.quo_hi[3 - i] = st.q;
      end
      s1_data_in.rem = rem;
   end

   // stage two: lower quotient digits, aad sum, flag mask
   always_comb begin
      logic [7:0]        rem;
      logic [3:0]        quo_lo;
      logic [15:0]       sum;
      xbcd_pkg::div_type st;
      rem = s1_data_ff.rem;
      quo_lo = 4'd0;
      for (int i = 0; i < xbcd_pkg::DIV_STEPS; i++) begin
         st = xbcd_pkg::div_step(rem, s1_data_ff.al[3 - i], s1_data_ff.base);
         rem = st.rem;
         quo_lo[3 - i] = st.q;
      end
      sum = s1_data_ff.prod + {8'd0, s1_data_ff.al};
      s2_data_in.al = s1_data_ff.res_al;
      s2_data_in.ah = s1_data_ff.res_ah;
      s2_data_in.cf = s1_data_ff.res_cf;
      s2_data_in.af = s1_data_ff.res_af;
      s2_data_in.of = 1'b0;
      s2_data_in.mask = 6'd0;
      s2_data_in.derr = 1'b0;
      case (s1_data_ff.op) inside
         xbcd_pkg::OP_DAA, xbcd_pkg::OP_DAS: begin
            s2_data_in.mask = xbcd_pkg::MASK_ARITH;
         end
         xbcd_pkg::OP_AAA, xbcd_pkg::OP_AAS: begin
            s2_data_in.mask = xbcd_pkg::MASK_ADJ;
         end
         xbcd_pkg::OP_AAM: begin
            s2_data_in.cf = 1'b0;
            s2_data_in.af = 1'b0;
            if (s1_data_ff.base == 8'd0) begin
               s2_data_in.derr = 1'b1;
            end else begin
               s2_data_in.al = rem;
               s2_data_in.ah = {s1_data_ff.quo_hi, quo_lo};
               s2_data_in.mask = xbcd_pkg::MASK_ARITH;
            end
         end
         xbcd_pkg::OP_AAD: begin
            s2_data_in.al = sum[7:0];
            s2_data_in.ah = 8'd0;
            s2_data_in.af = s1_data_ff.prod[3] ^ sum[3];
            s2_data_in.cf = |sum[15:8];
            s2_data_in.of = sum[7] ^ s1_data_ff.al[7];
            s2_data_in.mask = xbcd_pkg::MASK_ALL;
         end
         default: begin
         end
      endcase
   end

   // stage three: status flags and packing
   always_comb begin
      logic [5:0] m;
      m = s2_data_ff.mask;
      s3_data_in = 32'd0;
      s3_data_in[7:0] = s2_data_ff.al;
      s3_data_in[15:8] = s2_data_ff.ah;
      s3_data_in[16] = s2_data_ff.cf & m[0];
      s3_data_in[17] = s2_data_ff.af & m[1];
      s3_data_in[18] = s2_data_ff.al[7] & m[2];
      s3_data_in[19] = (s2_data_ff.al == 8'd0) & m[3];
      s3_data_in[20] = xbcd_pkg::even_parity(s2_data_ff.al) & m[4];
      s3_data_in[21] = s2_data_ff.of & m[5];
      s3_data_in[27:22] = m;
      s3_data_in[28] = s2_data_ff.derr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) s1_data_ff <= s1_data_in;
      if (en2) s2_data_ff <= s2_data_in;
      if (en3) s3_data_ff <= s3_data_in;
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata = s3_data_ff;

   `XBCD_ASSERT_NOW(a_derr_no_flags, rsp_tvalid && rsp_tdata[28], rsp_tdata[27:22] == 6'd0, "divide error with flags written")
   `XBCD_ASSERT_NOW(a_flags_masked, rsp_tvalid, (rsp_tdata[21:16] & ~rsp_tdata[27:22]) == 6'd0, "flag set but not written")
   `XBCD_ASSERT_NOW(a_aad_clears_ah, rsp_tvalid && rsp_tdata[27], rsp_tdata[15:8] == 8'd0, "overflow written but ah not cleared")
   `XBCD_ASSERT_NOW(a_stall_only_full, !req_tready, s1_valid_ff && s2_valid_ff && s3_valid_ff, "input stalled with a bubble in the pipe")

endmodule
